// File: hw/rtl/linked_list_node_pool_macros.svh
// ---------------------------------------------------------------------------
// Linked list node pool assertion macros
// Shared assertion shorthands for the node pool RTL.
// ---------------------------------------------------------------------------
`ifndef LINKED_LIST_NODE_POOL_MACROS_SVH
`define LINKED_LIST_NODE_POOL_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define LLNP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define LLNP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/llnp_pkg.sv
// ---------------------------------------------------------------------------
// Linked list node pool package
// Link width, null marker, request kinds and status codes.
// ---------------------------------------------------------------------------
package llnp_pkg;

   localparam int LINK_W = 7;
   localparam logic [LINK_W-1:0] NULL_LINK = 7'd64;

   typedef enum logic [1:0] {
      KIND_INS_HEAD  = 2'd0,
      KIND_DEL_AFTER = 2'd1,
      KIND_INS_AFTER = 2'd2,
      KIND_READ_OUT  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_BAD_NODE = 2'd2
   } status_type;

endpackage

// File: hw/rtl/linked_list_node_pool.sv
// ---------------------------------------------------------------------------
// Linked list node pool
// Singly linked list kept in a fixed pool of nodes held in two memories.
// ---------------------------------------------------------------------------
// The list lives in a value memory and a next-link memory, both with a
// registered synchronous read; nodes are taken from the pool in order and
// are never reused. One request is worked on at a time. An insert at the
// head, and any request rejected with an error status on arrival, goes
// straight to its response. A delete of the head reads the head's link
// and makes it the head. A delete after a node reads that node's link,
// fails if there is no successor, and else copies the successor's link
// into it. An insert after a node reads that node's link, writes it into
// the new node, then links that node to the new one. A read-out sends one
// node per cycle while the response side does not stall, or an empty
// answer for an empty list. Every response sits in an output register, so
// the next request is taken and started while the previous response waits to be taken.
// ---------------------------------------------------------------------------
`include "linked_list_node_pool_macros.svh"

module linked_list_node_pool #(
   parameter int NODE_COUNT = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [llnp_pkg::LINK_W-1:0] req_node_number,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_value_res,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_last,
   output logic                        rsp_empty_res
);
   import llnp_pkg::*;

   localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam logic [LINK_W-1:0] POOL_SIZE = LINK_W'(NODE_COUNT);
   localparam logic [LINK_W-1:0] LAST_COUNT = LINK_W'(NODE_COUNT - 1);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_INS_LINK = 8'b0000_0010,
      S_INS_HOOK = 8'b0000_0100,
      S_DEL_HEAD = 8'b0000_1000,
      S_DEL_SUCC = 8'b0001_0000,
      S_DEL_SKIP = 8'b0010_0000,
      S_WALK     = 8'b0100_0000,
      S_RESP     = 8'b1000_0000
   } state_type;

   logic [31:0]       value_mem [NODE_COUNT];
   logic [LINK_W-1:0] next_mem  [NODE_COUNT];

   state_type         state_ff, state_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] free_ff, free_in;
   logic [IDX_W-1:0]  ref_ff, ref_in;
   logic [LINK_W-1:0] count_ff, count_in;
   status_type        st_ff, st_in;
   logic              empty_ff, empty_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_empty_ff, rsp_empty_in;

   logic [31:0]       val_rd_ff;
   logic [LINK_W-1:0] nxt_rd_ff;

   logic              rd_en;
   logic              val_rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              nxt_we;
   logic [IDX_W-1:0]  nxt_waddr;
   logic [LINK_W-1:0] nxt_wdata;
   logic              val_we;

   logic              req_accept;
   logic              out_free;
   logic              pool_full;
   logic              head_live;
   logic              succ_live;
   logic              walk_fin;
   logic [IDX_W-1:0]  free_idx;
   logic [IDX_W-1:0]  req_ref;
   logic [LINK_W-1:0] num_minus_one;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // A link names a live slot only if that slot was handed out already.
   assign pool_full     = (free_ff >= POOL_SIZE);
   assign head_live     = (head_ff < free_ff);
   assign succ_live     = (nxt_rd_ff < free_ff);
   assign walk_fin      = !succ_live || (count_ff == LAST_COUNT);
   assign free_idx      = free_ff[IDX_W-1:0];
   assign num_minus_one = req_node_number - LINK_W'(1);
   assign req_ref       = num_minus_one[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      free_in   = free_ff;
      ref_in    = ref_ff;
      count_in  = count_ff;
      st_in     = st_ff;
      empty_in  = empty_ff;
      rd_en     = 1'b0;
      val_rd_en = 1'b0;
      rd_addr   = '0;
      nxt_we    = 1'b0;
      nxt_waddr = '0;
      nxt_wdata = '0;
      val_we    = 1'b0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               st_in    = STATUS_OK;
               empty_in = 1'b0;
               state_in = S_RESP;
               case (kind_type'(req_kind))
                  KIND_INS_HEAD: begin
                     if (pool_full) begin
                        st_in = STATUS_FULL;
                     end else begin
                        val_we    = 1'b1;
                        nxt_we    = 1'b1;
                        nxt_waddr = free_idx;
                        nxt_wdata = head_ff;
                        head_in   = free_ff;
                        free_in   = free_ff + LINK_W'(1);
                     end
                  end
                  KIND_INS_AFTER: begin
                     if (req_node_number == '0 || req_node_number > free_ff) begin
                        st_in = STATUS_BAD_NODE;
                     end else if (pool_full) begin
                        st_in = STATUS_FULL;
                     end else begin
                        val_we   = 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = req_ref;
                        ref_in   = req_ref;
                        state_in = S_INS_LINK;
                     end
                  end
                  KIND_DEL_AFTER: begin
                     if (req_node_number == '0) begin
                        if (!head_live) begin
                           st_in = STATUS_BAD_NODE;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = head_ff[IDX_W-1:0];
                           state_in = S_DEL_HEAD;
                        end
                     end else if (req_node_number > free_ff) begin
                        st_in = STATUS_BAD_NODE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_ref;
                        ref_in   = req_ref;
                        state_in = S_DEL_SUCC;
                     end
                  end
                  default: begin
                     if (!head_live) begin
                        empty_in = 1'b1;
                     end else begin
                        rd_en     = 1'b1;
                        val_rd_en = 1'b1;
                        rd_addr   = head_ff[IDX_W-1:0];
                        count_in  = '0;
                        state_in  = S_WALK;
                     end
                  end
               endcase
            end
         end
         S_INS_LINK: begin
            // The new node takes over the reference node's successor.
            nxt_we    = 1'b1;
            nxt_waddr = free_idx;
            nxt_wdata = nxt_rd_ff;
            state_in  = S_INS_HOOK;
         end
         S_INS_HOOK: begin
            nxt_we    = 1'b1;
            nxt_waddr = ref_ff;
            nxt_wdata = free_ff;
            free_in   = free_ff + LINK_W'(1);
            state_in  = S_RESP;
         end
         S_DEL_HEAD: begin
            head_in  = nxt_rd_ff;
            state_in = S_RESP;
         end
         S_DEL_SUCC: begin
            if (!succ_live) begin
               st_in    = STATUS_BAD_NODE;
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = nxt_rd_ff[IDX_W-1:0];
               state_in = S_DEL_SKIP;
            end
         end
         S_DEL_SKIP: begin
            nxt_we    = 1'b1;
            nxt_waddr = ref_ff;
            nxt_wdata = nxt_rd_ff;
            state_in  = S_RESP;
         end
         S_WALK: begin
            // Read data holds until the node is sent, so a stall just waits.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_rd_ff;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = walk_fin;
               rsp_empty_in  = 1'b0;
               if (walk_fin) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en     = 1'b1;
                  val_rd_en = 1'b1;
                  rd_addr   = nxt_rd_ff[IDX_W-1:0];
                  count_in  = count_ff + LINK_W'(1);
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = st_ff;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = empty_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_LINK;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_ff        <= ref_in;
      count_ff      <= count_in;
      st_ff         <= st_in;
      empty_ff      <= empty_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem[free_idx] <= req_value;
      end
      if (val_rd_en) begin
         val_rd_ff <= value_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         next_mem[nxt_waddr] <= nxt_wdata;
      end
      if (rd_en) begin
         nxt_rd_ff <= next_mem[rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

   `LLNP_ASSERT_NOW(a_free_bound, 1'b1, free_ff <= POOL_SIZE, "pool count past pool size")
   `LLNP_ASSERT_NOW(a_read_live, rd_en, LINK_W'(rd_addr) < free_ff, "read of a slot not handed out")
   `LLNP_ASSERT_NEXT(a_walk_keeps, state_ff == S_WALK, $stable(head_ff) && $stable(free_ff),
      "list state changed during read-out")
   `LLNP_ASSERT_NOW(a_empty_last, rsp_valid && rsp_empty_res,
      rsp_last && rsp_status == STATUS_OK, "empty answer not a single final response")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Linked list node pool testbench
// Drives insert, delete and read-out requests into the node pool, keeps its
// own copy of the list to predict every response, and compares each
// response field by field under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb;
   import llnp_pkg::*;

   localparam int NODE_COUNT = 64;

   typedef struct {
      logic signed [31:0] value;
      status_type         status;
      logic               last;
      logic               is_empty;
   } list_answer_type;

   typedef struct {
      kind_type           kind;
      logic [6:0]         node;
      logic signed [31:0] value;
      bit                 typed;
      status_type         status;
      bit                 is_empty;
   } plan_row_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_kind = KIND_INS_HEAD;
   logic [LINK_W-1:0]   req_node_number = '0;
   logic signed [31:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [31:0]  rsp_value_res;
   logic [1:0]          rsp_status;
   logic                rsp_last;
   logic                rsp_empty_res;

   // Shadow copy of the pool.
   logic signed [31:0]  pool_value [NODE_COUNT];
   logic [6:0]          pool_link [NODE_COUNT];
   logic [6:0]          head_link;
   logic [6:0]          free_count;

   list_answer_type     expected_answers [$];
   list_answer_type     step_answers [$];

   int                  error_count = 0;
   int                  request_count = 0;
   int                  response_count = 0;
   int                  full_count = 0;
   int                  longest_walk = 0;
   int                  burst_left = 0;

   // Directed requests; only results that are obvious are typed in.
   plan_row_type directed_plan [25] = '{
      '{KIND_READ_OUT,  7'd0,  32'sd0,           1'b1, STATUS_OK,       1'b1},
      '{KIND_DEL_AFTER, 7'd0,  32'sd0,           1'b1, STATUS_BAD_NODE, 1'b0},
      '{KIND_INS_AFTER, 7'd0,  32'sd5,           1'b1, STATUS_BAD_NODE, 1'b0},
      '{KIND_INS_AFTER, 7'd1,  32'sd6,           1'b1, STATUS_BAD_NODE, 1'b0},
      '{KIND_DEL_AFTER, 7'd1,  32'sd0,           1'b1, STATUS_BAD_NODE, 1'b0},
      '{KIND_DEL_AFTER, 7'd64, 32'sd0,           1'b1, STATUS_BAD_NODE, 1'b0},
      '{KIND_INS_HEAD,  7'd0,  32'h7FFF_FFFF,    1'b1, STATUS_OK,       1'b0},
      '{KIND_INS_HEAD,  7'd64, 32'h8000_0000,    1'b0, STATUS_OK,       1'b0},
      '{KIND_INS_AFTER, 7'd1,  32'hFFFF_FFFF,    1'b0, STATUS_OK,       1'b0},
      '{KIND_INS_AFTER, 7'd3,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_READ_OUT,  7'd0,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_DEL_AFTER, 7'd1,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_DEL_AFTER, 7'd3,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_INS_AFTER, 7'd3,  32'h5555_5555,    1'b0, STATUS_OK,       1'b0},
      '{KIND_DEL_AFTER, 7'd4,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_DEL_AFTER, 7'd0,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_READ_OUT,  7'd127, 32'h1234_5678,   1'b0, STATUS_OK,       1'b0},
      '{KIND_INS_AFTER, 7'd6,  32'sd1,           1'b1, STATUS_BAD_NODE, 1'b0},
      '{KIND_INS_HEAD,  7'd0,  32'hAAAA_AAAA,    1'b0, STATUS_OK,       1'b0},
      '{KIND_READ_OUT,  7'd0,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_DEL_AFTER, 7'd0,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_DEL_AFTER, 7'd0,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_DEL_AFTER, 7'd0,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_READ_OUT,  7'd0,  32'sd0,           1'b0, STATUS_OK,       1'b0},
      '{KIND_DEL_AFTER, 7'd0,  32'sd0,           1'b0, STATUS_OK,       1'b0}
   };

   linked_list_node_pool #(
      .NODE_COUNT(NODE_COUNT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_node_number(req_node_number),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value_res  (rsp_value_res),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .rsp_empty_res  (rsp_empty_res)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit in_pool(logic [6:0] slot);
      return slot < NODE_COUNT && slot < free_count;
   endfunction

   function automatic void add_answer(logic signed [31:0] value, status_type status,
                                      logic last, logic is_empty);
      list_answer_type ans;
      ans.value = value;
      ans.status = status;
      ans.last = last;
      ans.is_empty = is_empty;
      step_answers.push_back(ans);
   endfunction

   // Applies one request to the shadow list and collects its responses.
   function automatic void apply_list_request(kind_type kind, logic [6:0] node,
                                              logic signed [31:0] value);
      logic [6:0] cur;
      logic [6:0] nxt;
      logic [5:0] ref_slot;
      int         walked;
      status_type status;
      status = STATUS_OK;
      walked = 0;
      ref_slot = 6'(node - 7'd1);
      case (kind)
         KIND_READ_OUT: begin
            cur = head_link;
            if (!in_pool(cur)) begin
               add_answer(32'sd0, STATUS_OK, 1'b1, 1'b1);
            end else begin
               while (in_pool(cur) && walked < NODE_COUNT) begin
                  nxt = pool_link[cur[5:0]];
                  add_answer(pool_value[cur[5:0]], STATUS_OK,
                             !in_pool(nxt) || (walked + 1 >= NODE_COUNT), 1'b0);
                  walked++;
                  cur = nxt;
               end
               if (walked > longest_walk) longest_walk = walked;
            end
            return;
         end
         KIND_INS_HEAD: begin
            if (free_count >= NODE_COUNT) begin
               status = STATUS_FULL;
            end else begin
               pool_value[free_count[5:0]] = value;
               pool_link[free_count[5:0]] = head_link;
               head_link = free_count;
               free_count = free_count + 7'd1;
            end
         end
         KIND_INS_AFTER: begin
            if (node == 7'd0 || node > free_count) begin
               status = STATUS_BAD_NODE;
            end else if (free_count >= NODE_COUNT) begin
               status = STATUS_FULL;
            end else begin
               pool_value[free_count[5:0]] = value;
               pool_link[free_count[5:0]] = pool_link[ref_slot];
               pool_link[ref_slot] = free_count;
               free_count = free_count + 7'd1;
            end
         end
         default: begin
            if (node == 7'd0) begin
               if (!in_pool(head_link)) status = STATUS_BAD_NODE;
               else head_link = pool_link[head_link[5:0]];
            end else if (node > free_count) begin
               status = STATUS_BAD_NODE;
            end else begin
               nxt = pool_link[ref_slot];
               if (!in_pool(nxt)) status = STATUS_BAD_NODE;
               else pool_link[ref_slot] = pool_link[nxt[5:0]];
            end
         end
      endcase
      if (status == STATUS_FULL) full_count++;
      add_answer(32'sd0, status, 1'b1, 1'b0);
   endfunction

   // Sends one request in bursts with random gaps, then records its responses.
   task automatic issue_request(input kind_type kind, input logic [6:0] node,
                                input logic signed [31:0] value, input bit typed,
                                input list_answer_type typed_ans);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_node_number <= node;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      request_count++;
      step_answers.delete();
      apply_list_request(kind, node, value);
      if (typed) begin
         step_answers.delete();
         step_answers.push_back(typed_ans);
      end
      foreach (step_answers[i]) expected_answers.push_back(step_answers[i]);
   endtask

   function automatic logic [6:0] pick_node();
      if (free_count != 0 && $urandom_range(0, 9) < 8)
         return 7'($urandom_range(1, free_count));
      return 7'($urandom_range(0, NODE_COUNT));
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // Receiver stall pattern: free-flowing, scattered stalls, or long holds.
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
         mode_left <= 0;
         hold_left <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(30, 150);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               if (hold_left > 0) begin
                  hold_left <= hold_left - 1;
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
                  if ($urandom_range(0, 5) == 0) hold_left <= $urandom_range(1, 10);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      list_answer_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         response_count++;
         if (expected_answers.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response value=%0d status=%0d last=%0b empty=%0b",
                     $time, rsp_value_res, rsp_status, rsp_last, rsp_empty_res);
         end else begin
            exp = expected_answers.pop_front();
            if (rsp_value_res !== exp.value) begin
               error_count++;
               $display("%0t: value_res expected %0d actual %0d",
                        $time, exp.value, rsp_value_res);
            end
            if (rsp_status !== exp.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d", $time, exp.status, rsp_status);
            end
            if (rsp_last !== exp.last) begin
               error_count++;
               $display("%0t: last expected %0b actual %0b", $time, exp.last, rsp_last);
            end
            if (rsp_empty_res !== exp.is_empty) begin
               error_count++;
               $display("%0t: empty_res expected %0b actual %0b",
                        $time, exp.is_empty, rsp_empty_res);
            end
         end
      end
   end

   initial begin
      list_answer_type typed_ans;
      list_answer_type no_ans;
      int              fill_items;
      int              r;
      head_link = NULL_LINK;
      free_count = '0;
      no_ans = '{32'sd0, STATUS_OK, 1'b0, 1'b0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         typed_ans = '{32'sd0, directed_plan[i].status, 1'b1, directed_plan[i].is_empty};
         issue_request(directed_plan[i].kind, directed_plan[i].node, directed_plan[i].value,
                       directed_plan[i].typed, typed_ans);
      end

      // Fill the pool with mostly well-formed inserts, then walk the full list.
      fill_items = 0;
      while (free_count < NODE_COUNT && fill_items < 110) begin
         r = $urandom_range(0, 19);
         if (r < 3) issue_request(KIND_READ_OUT, pick_node(), pick_value(), 1'b0, no_ans);
         else if (r < 11) issue_request(KIND_INS_HEAD, pick_node(), pick_value(), 1'b0, no_ans);
         else issue_request(KIND_INS_AFTER, pick_node(), pick_value(), 1'b0, no_ans);
         fill_items++;
      end
      issue_request(KIND_READ_OUT, 7'd0, 32'sd0, 1'b0, no_ans);

      // Deletes, rejected inserts on a full pool, and read-outs of a shrinking list.
      repeat (20) begin
         r = $urandom_range(0, 19);
         if (r < 3) issue_request(KIND_DEL_AFTER, 7'd0, pick_value(), 1'b0, no_ans);
         else if (r < 9) issue_request(KIND_DEL_AFTER, pick_node(), pick_value(), 1'b0, no_ans);
         else if (r < 11) issue_request(KIND_INS_HEAD, pick_node(), pick_value(), 1'b0, no_ans);
         else if (r < 13) issue_request(KIND_INS_AFTER, pick_node(), pick_value(), 1'b0, no_ans);
         else if (r < 18) issue_request(KIND_READ_OUT, pick_node(), pick_value(), 1'b0, no_ans);
         else issue_request(KIND_DEL_AFTER, 7'($urandom_range(0, NODE_COUNT)), pick_value(),
                            1'b0, no_ans);
      end
      req_valid <= 1'b0;

      while (expected_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d requests and %0d responses; longest read-out %0d nodes.",
               request_count, response_count, longest_walk);
      $display("Pool-full rejections: %0d; mismatches: %0d.", full_count, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #800000;
      $display("Timeout with %0d responses still outstanding.", expected_answers.size());
      $display("Verification failed");
      $finish;
   end

endmodule
